// ===== src/lif_pkg.sv =====
// Shared types and constants for the leaky integrate-and-fire neuron.
package lif_pkg;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RESET_VOLTAGE     = 3'd0,
		REG_THRESHOLD_VOLTAGE = 3'd1,
		REG_REST_POTENTIAL    = 3'd2,
		REG_TIME_CONSTANT     = 3'd3,
		REG_BIAS_CURRENT      = 3'd4,
		REG_TIME_STEP         = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SAT,
		ST_MUL,
		ST_WB
	} ctrl_state_t;

	typedef struct packed {
		logic in_ready;
		logic accept;
		logic div_start;
		logic sat_en;
		logic mul_en;
		logic commit;
	} lif_cmd_t;

	typedef struct packed {
		logic bypass_in;
		logic div_done;
		logic out_free;
	} lif_status_t;

endpackage

// ===== src/leaky_integrate_and_fire_neuron.sv =====
// Top level of the leaky integrate-and-fire neuron.
// Each request is one tick: the membrane voltage V (signed, FRAC_BITS fraction bits) either
// takes the reset voltage (restart, or the tick after a spike) or integrates
// V + step*((E-V)/tau + Iex) + weight with saturation, then is compared with the threshold (a restart never fires).
// One request is processed at a time. An integrating tick runs the serial divide by tau,
// which produces one quotient bit per cycle, then the saturate, multiply and writeback
// states; a restart or post-spike tick goes straight to writeback. The next request can
// be accepted in the cycle after the result is registered.
// The result sits in an output register, so the next request is accepted while it waits.
// The user must write registers only while no request is in flight; the block does not enforce it.
module leaky_integrate_and_fire_neuron import lif_pkg::*; #(
	parameter int VOLT_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [CFG_IDX_W-1:0]                cfg_index,
	input  logic [VOLT_WIDTH-1:0]               cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((VOLT_WIDTH+7)/8)*8-1:0]     s_tdata,  // syn_weight
	input  logic                                s_tuser,  // restart
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [((VOLT_WIDTH+7)/8)*8-1:0]     m_tdata,  // membrane
	output logic                                m_tuser   // fire
);

	localparam int TDW = ((VOLT_WIDTH + 7) / 8) * 8;

	lif_cmd_t              cmd;
	lif_status_t           status;
	logic [VOLT_WIDTH-1:0] out_membrane;

	lif_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.status   (status),
		.cmd      (cmd)
	);

	lif_dp #(
		.W(VOLT_WIDTH),
		.F(FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_weight    (s_tdata[VOLT_WIDTH-1:0]),
		.in_restart   (s_tuser),
		.out_ready    (m_tready),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (m_tvalid),
		.out_membrane (out_membrane),
		.out_fire     (m_tuser)
	);

	assign s_tready = cmd.in_ready;
	assign m_tdata  = TDW'(out_membrane);

endmodule

// ===== src/lif_div.sv =====
// Restoring serial divider for unsigned magnitudes, one quotient bit per cycle.
module lif_div #(
	parameter int DW = 49,
	parameter int DV = 31
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [DV-1:0] divisor,
	output logic [DW-1:0] quotient,
	output logic          done
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] quo_q;
	logic [DV-1:0] rem_q;
	logic [DV-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DV:0]   shifted;
	logic [DV:0]   diff;
	logic          ge;

	assign shifted = {rem_q, quo_q[DW-1]};
	assign ge      = shifted >= {1'b0, div_q};
	assign diff    = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= ge ? diff[DV-1:0] : shifted[DV-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== src/lif_dp.sv =====
// Datapath: configuration registers, neuron state, divider, multiplier and writeback.
module lif_dp import lif_pkg::*; #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [W-1:0]         cfg_data,
	input  logic [W-1:0]         in_weight,
	input  logic                 in_restart,
	input  logic                 out_ready,
	input  lif_cmd_t             cmd,
	output lif_status_t          status,
	output logic                 out_valid,
	output logic [W-1:0]         out_membrane,
	output logic                 out_fire
);

	localparam int DW = W + 1 + F;
	localparam int DV = W - 1;
	localparam int TW = DW + 2;
	localparam int PW = 2 * W;
	localparam int SW = PW + 2;

	logic signed [W-1:0]  reset_v_q;
	logic signed [W-1:0]  thresh_q;
	logic signed [W-1:0]  rest_q;
	logic        [DV-1:0] tau_q;
	logic signed [W-1:0]  bias_q;
	logic        [DV-1:0] step_q;

	logic signed [W-1:0]  membrane_q;
	logic                 pending_q;
	logic signed [W-1:0]  weight_q;
	logic                 restart_q;
	logic                 d_neg_q;
	logic                 d_zero_q;
	logic signed [W-1:0]  t_q;
	logic signed [PW-1:0] prod_q;
	logic                 out_valid_q;
	logic        [W-1:0]  out_mem_q;
	logic                 out_fire_q;

	logic signed [W:0]    d;
	logic        [W:0]    d_mag;
	logic        [DW-1:0] dividend;
	logic        [DW-1:0] quotient;
	logic                 div_done;
	logic signed [DW:0]   qs;
	logic signed [TW-1:0] t_sum;
	logic signed [W-1:0]  t_sat;
	logic signed [PW-1:0] prod_c;
	logic signed [PW-1:0] p;
	logic signed [SW-1:0] v_sum;
	logic signed [W-1:0]  v_sat;
	logic signed [W-1:0]  new_v;
	logic                 use_reset;
	logic                 fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_v_q <= '0;
			thresh_q  <= W'(1) << F;
			rest_q    <= '0;
			tau_q     <= DV'(1) << F;
			bias_q    <= '0;
			step_q    <= DV'(1) << F;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_RESET_VOLTAGE:     reset_v_q <= cfg_data;
				REG_THRESHOLD_VOLTAGE: thresh_q  <= cfg_data;
				REG_REST_POTENTIAL:    rest_q    <= cfg_data;
				REG_TIME_CONSTANT:     tau_q     <= cfg_data[DV-1:0];
				REG_BIAS_CURRENT:      bias_q    <= cfg_data;
				REG_TIME_STEP:         step_q    <= cfg_data[DV-1:0];
				default: ;
			endcase
		end
	end

	assign d        = {rest_q[W-1], rest_q} - {membrane_q[W-1], membrane_q};
	assign d_mag    = d[W] ? (W+1)'(-d) : d;
	assign dividend = {d_mag, {F{1'b0}}};

	lif_div #(
		.DW(DW),
		.DV(DV)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (tau_q),
		.quotient (quotient),
		.done     (div_done)
	);

	always_comb begin
		if (tau_q == '0) begin
			if (d_zero_q)
				qs = '0;
			else if (d_neg_q)
				qs = {{(DW-W+2){1'b1}}, {(W-1){1'b0}}};
			else
				qs = {{(DW-W+2){1'b0}}, {(W-1){1'b1}}};
		end else begin
			qs = d_neg_q ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
		end
	end

	assign t_sum = {qs[DW], qs} + {{(TW-W){bias_q[W-1]}}, bias_q};

	always_comb begin
		if ((&t_sum[TW-1:W-1]) || !(|t_sum[TW-1:W-1]))
			t_sat = t_sum[W-1:0];
		else if (t_sum[TW-1])
			t_sat = {1'b1, {(W-1){1'b0}}};
		else
			t_sat = {1'b0, {(W-1){1'b1}}};
	end

	assign prod_c = $signed({1'b0, step_q}) * t_q;
	assign p      = prod_q >>> F;
	assign v_sum  = {{(SW-W){membrane_q[W-1]}}, membrane_q}
		+ {{(SW-PW){p[PW-1]}}, p}
		+ {{(SW-W){weight_q[W-1]}}, weight_q};

	always_comb begin
		if ((&v_sum[SW-1:W-1]) || !(|v_sum[SW-1:W-1]))
			v_sat = v_sum[W-1:0];
		else if (v_sum[SW-1])
			v_sat = {1'b1, {(W-1){1'b0}}};
		else
			v_sat = {1'b0, {(W-1){1'b1}}};
	end

	assign use_reset = restart_q || pending_q;
	assign new_v     = use_reset ? reset_v_q : v_sat;
	assign fire      = !restart_q && (new_v >= thresh_q);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			weight_q  <= in_weight;
			restart_q <= in_restart;
			d_neg_q   <= d[W];
			d_zero_q  <= (d == '0);
		end
		if (cmd.sat_en)
			t_q <= t_sat;
		if (cmd.mul_en)
			prod_q <= prod_c;
		if (cmd.commit) begin
			out_mem_q  <= new_v;
			out_fire_q <= fire;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			membrane_q  <= '0;
			pending_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				membrane_q  <= new_v;
				pending_q   <= fire;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.bypass_in = in_restart || pending_q;
	assign status.div_done  = div_done;
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign out_membrane = out_mem_q;
	assign out_fire     = out_fire_q;

endmodule

// ===== src/lif_ctrl.sv =====
// Controller state machine sequencing accept, divide, saturate, multiply and writeback.
module lif_ctrl import lif_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  lif_status_t status,
	output lif_cmd_t    cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = status.bypass_in ? ST_WB : ST_DIV;
			end
			ST_DIV: begin
				if (status.div_done)
					state_d = ST_SAT;
			end
			ST_SAT:  state_d = ST_MUL;
			ST_MUL:  state_d = ST_WB;
			ST_WB: begin
				if (status.out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.in_ready  = 1'b1;
				cmd.accept    = in_valid;
				cmd.div_start = in_valid && !status.bypass_in;
			end
			ST_DIV:  ;
			ST_SAT:  cmd.sat_en = 1'b1;
			ST_MUL:  cmd.mul_en = 1'b1;
			ST_WB:   cmd.commit = status.out_free;
			default: ;
		endcase
	end

endmodule

// ===== test/tb.sv =====
// Testbench for the leaky integrate-and-fire neuron: stream driver, monitor and tick predictor.
module tb;
	import lif_pkg::*;

	localparam int     VW      = 32;
	localparam int     FB      = 16;
	localparam int     LATENCY = VW + FB + 12;
	localparam longint VOLT_MAX = (longint'(1) <<< (VW - 1)) - 1;
	localparam longint VOLT_MIN = -VOLT_MAX - 1;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd6;
	localparam logic [VW-1:0] V_TOP = 32'h7fff_ffff;
	localparam logic [VW-1:0] V_BOT = 32'h8000_0000;
	localparam logic [VW-1:0] ONE   = 32'h0001_0000;

	typedef struct packed {
		logic signed [VW-1:0] weight;
		logic                 restart;
	} tick_t;

	typedef struct packed {
		logic                 fire;
		logic signed [VW-1:0] membrane;
	} spike_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [VW-1:0]        cfg_data  = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [VW-1:0]        s_tdata   = '0;  // syn_weight
	logic                 s_tuser   = 1'b0; // restart
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [VW-1:0]        m_tdata;         // membrane
	logic                 m_tuser;         // fire

	tick_t  tick_q[$];
	spike_t spike_q[$];
	logic   req_done  = 1'b0;
	int     idle_pct  = 0;
	int     stall_pct = 0;
	int     fault_cnt = 0;

	longint rst_v  = 0;
	longint thr_v  = 65536;
	longint rest_v = 0;
	longint tau    = 65536;
	longint bias   = 0;
	longint step   = 65536;
	longint mem_v  = 0;
	bit     armed  = 1'b0;

	leaky_integrate_and_fire_neuron dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	function automatic longint clamp_volt(longint x);
		if (x > VOLT_MAX)
			return VOLT_MAX;
		if (x < VOLT_MIN)
			return VOLT_MIN;
		return x;
	endfunction

	function automatic void load_reg(logic [CFG_IDX_W-1:0] idx, logic [VW-1:0] val);
		case (idx)
			REG_RESET_VOLTAGE:     rst_v  = longint'(signed'(val));
			REG_THRESHOLD_VOLTAGE: thr_v  = longint'(signed'(val));
			REG_REST_POTENTIAL:    rest_v = longint'(signed'(val));
			REG_TIME_CONSTANT:     tau    = longint'({1'b0, val[VW-2:0]});
			REG_BIAS_CURRENT:      bias   = longint'(signed'(val));
			REG_TIME_STEP:         step   = longint'({1'b0, val[VW-2:0]});
			default: ;
		endcase
	endfunction

	function automatic spike_t integrate_tick(tick_t t);
		spike_t r;
		longint d, q, s, p;
		r.fire = 1'b0;
		if (t.restart) begin
			mem_v = rst_v;
			armed = 1'b0;
		end else begin
			if (armed) begin
				mem_v = rst_v;
				armed = 1'b0;
			end else begin
				d = rest_v - mem_v;
				if (tau == 0)
					q = (d > 0) ? VOLT_MAX : ((d < 0) ? VOLT_MIN : 0);
				else
					q = (d <<< FB) / tau;
				s = clamp_volt(q + bias);
				p = (step * s) >>> FB;
				mem_v = clamp_volt(mem_v + p + longint'(t.weight));
			end
			if (mem_v >= thr_v) begin
				r.fire = 1'b1;
				armed = 1'b1;
			end
		end
		r.membrane = mem_v[VW-1:0];
		return r;
	endfunction

	function automatic logic [VW-1:0] rand_weight();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(0, 65536) - 16384;
		if (r < 80) begin
			case ($urandom_range(3))
				0: return V_TOP;
				1: return V_BOT;
				2: return '0;
				default: return '1;
			endcase
		end
		return $urandom();
	endfunction

	always @(posedge clk) begin : monitor
		tick_t  got;
		spike_t want;
		req_done <= arst_n && s_tvalid && s_tready;
		if (arst_n) begin
			if (cfg_we)
				load_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready) begin
				got.weight  = s_tdata;
				got.restart = s_tuser;
				spike_q.push_back(integrate_tick(got));
			end
			if (m_tvalid && m_tready) begin
				if (spike_q.size() == 0) begin
					$error("unexpected result: membrane %0d fire %0b",
						$signed(m_tdata), m_tuser);
					fault_cnt++;
				end else begin
					want = spike_q.pop_front();
					if (m_tuser !== want.fire) begin
						$error("fire: expected %0b, actual %0b", want.fire, m_tuser);
						fault_cnt++;
					end
					if (m_tdata !== want.membrane) begin
						$error("membrane: expected %0d, actual %0d",
							want.membrane, $signed(m_tdata));
						fault_cnt++;
					end
				end
			end
		end
	end

	always @(negedge clk) begin : driver
		tick_t nxt;
		if (arst_n) begin
			if (!s_tvalid || req_done) begin
				if (tick_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
					nxt = tick_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.weight;
					s_tuser  <= nxt.restart;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= $urandom_range(99) >= stall_pct;
		end
	end

	task automatic queue_tick(logic [VW-1:0] w, logic r);
		tick_t t;
		t.weight  = w;
		t.restart = r;
		tick_q.push_back(t);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VW-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic write_all(logic [VW-1:0] rv, logic [VW-1:0] th, logic [VW-1:0] e,
			logic [VW-1:0] tc, logic [VW-1:0] ib, logic [VW-1:0] st);
		write_reg(REG_RESET_VOLTAGE, rv);
		write_reg(REG_THRESHOLD_VOLTAGE, th);
		write_reg(REG_REST_POTENTIAL, e);
		write_reg(REG_TIME_CONSTANT, tc);
		write_reg(REG_BIAS_CURRENT, ib);
		write_reg(REG_TIME_STEP, st);
	endtask

	// hold until every request is taken and every result has arrived
	task automatic settle();
		do
			@(posedge clk);
		while (tick_q.size() != 0 || s_tvalid || spike_q.size() != 0);
		repeat (LATENCY) @(posedge clk);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		queue_tick('0, 1'b0);
		queue_tick(32'h0000_8000, 1'b0);
		queue_tick(ONE, 1'b0);
		queue_tick(V_TOP, 1'b0);
		queue_tick(V_TOP, 1'b0);
		queue_tick(V_BOT, 1'b1);
		queue_tick(V_BOT, 1'b0);
		queue_tick(V_BOT, 1'b0);
		queue_tick('1, 1'b0);
		queue_tick('0, 1'b0);
		settle();

		write_reg(REG_UNMAPPED, '1);
		write_all(32'h0002_0000, ONE, 32'h0005_0000, '0, '0, 32'h0000_0100);
		queue_tick(ONE, 1'b0);
		queue_tick('0, 1'b0);
		queue_tick('0, 1'b0);
		queue_tick('0, 1'b1);
		queue_tick(32'hfffd_0000, 1'b0);
		settle();

		write_reg(REG_REST_POTENTIAL, 32'h0002_0000);
		write_reg(REG_THRESHOLD_VOLTAGE, V_TOP);
		queue_tick('0, 1'b1);
		queue_tick('0, 1'b0);
		queue_tick(ONE, 1'b0);
		queue_tick('0, 1'b0);
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 58; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 58; end
				default: begin idle_pct = 38; stall_pct = 38; end
			endcase
			if (ph == 3)
				write_all(V_TOP, V_TOP, V_TOP, '1, V_TOP, '1);
			else if (ph == 7)
				write_all(V_BOT, V_BOT, V_BOT, 32'd1, V_BOT, '0);
			else if (ph == 5)
				write_all($urandom(), $urandom(), $urandom(), $urandom() | 32'd1,
					$urandom(), $urandom());
			else
				write_all($urandom_range(0, 131072) - 65536,
					$urandom_range(16384, 262144),
					$urandom_range(0, 131072) - 65536,
					$urandom_range(32768, 1048576),
					$urandom_range(0, 32768) - 8192,
					$urandom_range(4096, 65536));
			for (int i = 0; i < 60; i++)
				queue_tick(rand_weight(), $urandom_range(99) < 5);
			settle();
		end

		if (fault_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/lif_pkg.sv
src/lif_div.sv
src/lif_dp.sv
src/lif_ctrl.sv
src/leaky_integrate_and_fire_neuron.sv
test/tb.sv
